[design/rgbhsv_pkg.sv]
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by rgb_to_hsv_converter_unit.
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

  localparam int CH_W       = 8;              // colour channel width
  localparam int QW         = 16;             // Q0.16 result width
  localparam int DIV_BITS   = 4;              // quotient bits per divider stage
  localparam int DIV_STAGES = QW / DIV_BITS;  // divider pipeline depth
  localparam int HDEN_W     = CH_W + 3;       // 6*delta fits in 11 bits
  localparam int SDEN_W     = CH_W;           // max fits in 8 bits
  localparam int LATENCY    = 4 + DIV_STAGES; // start to done, in cycles

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_word_t;

  typedef struct packed {
    logic [QW-1:0]   hue;
    logic [QW-1:0]   saturation;
    logic [CH_W-1:0] brightness;
  } hsv_word_t;

  // Hue sector, chosen by the first maximal channel (red, green, blue)
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

endpackage

`default_nettype wire

[design/rgb_to_hsv_converter_unit.sv]
// RGB to HSV converter, one pixel per clock, fully pipelined.
// Depends on rgbhsv_pkg (word types, sector codes, divider sizing).
`timescale 1ns / 1ps
`default_nettype none

//  channel   ports                  direction  word
//  ------    ---------------------  ---------  ---------------------------
//  pixel     start, busy, pixel     in         red, green, blue (8 b each)
//  result    done, hsv              out        hue, saturation (16 b), brightness (8 b)
//
//  - A pixel is taken at every edge with start high; busy is always low, so a
//    new word may follow every cycle.
//  - The pipe holds three stages of min/max and operand set-up, four stages
//    of the two restoring dividers (4 quotient bits each) and one output
//    register.
//  - done is high for exactly one cycle with the result on hsv; the receiver
//    cannot hold it off, and nothing in the pipe ever waits.
//  - rst (synchronous) clears the valid bits only; data registers are free.

module rgb_to_hsv_converter_unit (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  output logic                     busy,
  input  rgbhsv_pkg::pixel_word_t  pixel,
  output logic                     done,
  output rgbhsv_pkg::hsv_word_t    hsv
);
  import rgbhsv_pkg::*;

  // Stage A: max, min, sector and signed channel difference
  typedef struct packed {
    logic [CH_W-1:0]       mx;
    logic [CH_W-1:0]       mn;
    sector_t               sector;
    logic signed [CH_W:0]  diff;
  } stage_a_t;

  // Stage B: delta
  typedef struct packed {
    logic [CH_W-1:0]       mx;
    logic [CH_W-1:0]       delta;
    sector_t               sector;
    logic signed [CH_W:0]  diff;
  } stage_b_t;

  // Divider pipeline word: both fraction divides run side by side
  typedef struct packed {
    logic [HDEN_W-1:0] h_rem;
    logic [HDEN_W-1:0] h_den;
    logic [QW-1:0]     h_quo;
    logic [SDEN_W-1:0] s_rem;
    logic [SDEN_W-1:0] s_den;
    logic [QW-1:0]     s_quo;
    logic [CH_W-1:0]   brightness;
    logic              hue_zero;
    logic              sat_zero;
    logic              sat_full;
  } div_word_t;

  // DIV_BITS restoring steps of q = floor(rem * 2^QW / den), rem < den
  function automatic div_word_t div_step(div_word_t cur);
    div_word_t         acc;
    logic [HDEN_W:0]   h_trial;
    logic [SDEN_W:0]   s_trial;
    acc = cur;
    for (int i = 0; i < DIV_BITS; i++) begin
      h_trial = {acc.h_rem, 1'b0};
      if (h_trial >= {1'b0, acc.h_den}) begin
        acc.h_rem = HDEN_W'(h_trial - {1'b0, acc.h_den});
        acc.h_quo = {acc.h_quo[QW-2:0], 1'b1};
      end else begin
        acc.h_rem = h_trial[HDEN_W-1:0];
        acc.h_quo = {acc.h_quo[QW-2:0], 1'b0};
      end
      s_trial = {acc.s_rem, 1'b0};
      if (s_trial >= {1'b0, acc.s_den}) begin
        acc.s_rem = SDEN_W'(s_trial - {1'b0, acc.s_den});
        acc.s_quo = {acc.s_quo[QW-2:0], 1'b1};
      end else begin
        acc.s_rem = s_trial[SDEN_W-1:0];
        acc.s_quo = {acc.s_quo[QW-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

  logic                  a_valid;
  stage_a_t              st_a;
  stage_a_t              st_a_next;
  logic                  b_valid;
  stage_b_t              st_b;
  div_word_t             div_init;
  logic [DIV_STAGES:0]   div_valid;
  div_word_t             div_pipe [DIV_STAGES+1];
  hsv_word_t             hsv_next;

  // Input stage is always free to take a word
  assign busy = 1'b0;

  // ---- Stage A: compare channels -------------------------------------------
  always_comb begin
    logic r_top;
    logic g_top;
    r_top = (pixel.red >= pixel.green) && (pixel.red >= pixel.blue);
    g_top = !r_top && (pixel.green >= pixel.blue);
    st_a_next = '0;
    if (r_top) begin
      st_a_next.sector = SEC_RED;
      st_a_next.mx     = pixel.red;
      st_a_next.diff   = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
    end else if (g_top) begin
      st_a_next.sector = SEC_GREEN;
      st_a_next.mx     = pixel.green;
      st_a_next.diff   = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
    end else begin
      st_a_next.sector = SEC_BLUE;
      st_a_next.mx     = pixel.blue;
      st_a_next.diff   = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
    end
    if ((pixel.red <= pixel.green) && (pixel.red <= pixel.blue)) begin
      st_a_next.mn = pixel.red;
    end else if (pixel.green <= pixel.blue) begin
      st_a_next.mn = pixel.green;
    end else begin
      st_a_next.mn = pixel.blue;
    end
  end

  always_ff @(posedge clk) begin
    st_a <= st_a_next;
    st_b.mx     <= st_a.mx;
    st_b.delta  <= st_a.mx - st_a.mn;
    st_b.sector <= st_a.sector;
    st_b.diff   <= st_a.diff;
  end

  // ---- Stage C: hue numerator, wrapped into [0, 6*delta) -------------------
  always_comb begin
    logic [HDEN_W-1:0]        den6;
    logic [HDEN_W-1:0]        koff;
    logic signed [HDEN_W+1:0] num;
    den6 = HDEN_W'({st_b.delta, 2'b00}) + HDEN_W'({st_b.delta, 1'b0});
    case (st_b.sector)
      SEC_GREEN: koff = HDEN_W'({st_b.delta, 1'b0});
      SEC_BLUE:  koff = HDEN_W'({st_b.delta, 2'b00});
      default:   koff = '0;
    endcase
    num = $signed({2'b00, koff}) + (HDEN_W+2)'(st_b.diff);
    // red sector with green below blue: add a full turn
    if (num < 0) begin
      num = num + $signed({2'b00, den6});
    end
    div_init            = '0;
    div_init.h_rem      = num[HDEN_W-1:0];
    div_init.h_den      = den6;
    div_init.s_rem      = st_b.delta;
    div_init.s_den      = st_b.mx;
    div_init.brightness = st_b.mx;
    div_init.hue_zero   = (st_b.delta == '0);
    div_init.sat_zero   = (st_b.mx == '0);
    div_init.sat_full   = (st_b.delta == st_b.mx) && (st_b.mx != '0);
  end

  always_ff @(posedge clk) begin
    div_pipe[0] <= div_init;
  end

  // ---- Divider stages ------------------------------------------------------
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    always_ff @(posedge clk) begin
      div_pipe[s+1] <= div_step(div_pipe[s]);
    end
  end

  // ---- Output stage --------------------------------------------------------
  always_comb begin
    hsv_next.brightness = div_pipe[DIV_STAGES].brightness;
    hsv_next.hue        = div_pipe[DIV_STAGES].hue_zero ? '0 : div_pipe[DIV_STAGES].h_quo;
    if (div_pipe[DIV_STAGES].sat_zero) begin
      hsv_next.saturation = '0;
    end else if (div_pipe[DIV_STAGES].sat_full) begin
      hsv_next.saturation = '1;
    end else begin
      hsv_next.saturation = div_pipe[DIV_STAGES].s_quo;
    end
  end

  always_ff @(posedge clk) begin
    hsv <= hsv_next;
  end

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      div_valid <= '0;
      done      <= 1'b0;
    end else begin
      a_valid   <= start && !busy;
      b_valid   <= a_valid;
      div_valid <= {div_valid[DIV_STAGES-1:0], b_valid};
      done      <= div_valid[DIV_STAGES];
    end
  end

  // ---- Checks --------------------------------------------------------------
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(LATENCY) done)
    else $error("accepted pixel did not give a result after the pipeline latency");

  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result strobe without a matching accepted pixel");

  a_black : assert property (@(posedge clk) disable iff (rst)
    (done && hsv.brightness == '0) |-> (hsv.hue == '0 && hsv.saturation == '0))
    else $error("black pixel gave non-zero hue or saturation");

  a_grey : assert property (@(posedge clk) disable iff (rst)
    (done && hsv.saturation == '0) |-> (hsv.hue == '0))
    else $error("grey pixel gave non-zero hue");

endmodule

`default_nettype wire
